[rtl/fps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int REG_W     = 16;
  localparam int IDX_W     = 3;

  // Q constants, rounded to nearest
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int C03   = ((3 << FRAC_BITS) + 5) / 10;
  localparam int C005  = ((5 << FRAC_BITS) + 50) / 100;
  localparam int C008  = ((8 << FRAC_BITS) + 50) / 100;
  localparam int C01   = ((1 << FRAC_BITS) + 5) / 10;
  localparam int C04   = ((4 << FRAC_BITS) + 5) / 10;

  localparam int TERM_SH = FRAC_BITS + 2;      // terms carry 2*FRAC_BITS+2 fraction bits
  localparam int ACC_SH  = 3 * FRAC_BITS + 2;  // after occlusion scale

  // internal widths
  localparam int NRM_W  = IN_W + 2;            // mapped normal, signed
  localparam int PRD_W  = NRM_W + REG_W;       // normal * light, signed
  localparam int PZ_W   = REG_W + FRAC_BITS - 1;
  localparam int DOT_W  = PRD_W + 2;
  localparam int DIFF_W = 19;
  localparam int SD_W   = 11;
  localparam int SSS_W  = SD_W + REG_W;
  localparam int FI_W   = 2 * REG_W;
  localparam int RIM_W  = IN_W + 11;
  localparam int DT_W   = 30;
  localparam int CMN_W  = 31;
  localparam int CH_W   = FI_W + 3;
  localparam int OCC_W  = CH_W + IN_W;
  localparam int SUM_W  = OCC_W + 1;
  localparam int LIM_W  = ACC_SH + 1;
  localparam int BYTE_W = LIM_W + 8;

  localparam int PIPE_DEPTH = 6;

  typedef enum logic [IDX_W-1:0] {
    REG_LIGHT_X   = 3'd0,
    REG_LIGHT_Y   = 3'd1,
    REG_LIGHT_Z   = 3'd2,
    REG_SCATTER   = 3'd3,
    REG_FRESNEL   = 3'd4,
    REG_IRIDESCE  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [REG_W-1:0] ldx;
    logic signed [REG_W-1:0] ldy;
    logic signed [REG_W-1:0] ldz;
    logic [REG_W-1:0]        scatter;
    logic [REG_W-1:0]        fresnel;
    logic [REG_W-1:0]        irid;
  } cfg_t;

  typedef struct packed {
    logic [IN_W-1:0] density;
    logic [IN_W-1:0] normal_x;
    logic [IN_W-1:0] normal_y;
    logic [IN_W-1:0] occlusion;
    logic [IN_W-1:0] rim_level;
  } pix_t;

  // front stage 1: raw products
  typedef struct packed {
    logic signed [PRD_W-1:0] px;
    logic signed [PRD_W-1:0] py;
    logic signed [PZ_W-1:0]  pz;
    logic [SSS_W-1:0]        sss;
    logic [FI_W-1:0]         fi;
    logic [RIM_W-1:0]        rim;
    logic [IN_W-1:0]         ao;
  } fr1_t;

  // front output: rounded diffuse and passed terms
  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [SSS_W-1:0]  sss;
    logic [FI_W-1:0]   fi;
    logic [RIM_W-1:0]  rim;
    logic [IN_W-1:0]   ao;
  } fr2_t;

  typedef struct packed {
    logic [2:0][CH_W-1:0] ch;
    logic [RIM_W-1:0]     rim;
    logic [IN_W-1:0]      ao;
  } mx1_t;

  typedef struct packed {
    logic [2:0][OCC_W-1:0] ch;
    logic [RIM_W-1:0]      rim;
  } mx2_t;

endpackage

`default_nettype wire

[rtl/fps_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fps_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire fps_pkg::pix_t pix_i,
  output logic               ready_o,
  output logic               valid_o,
  output fps_pkg::fr2_t      data_o,
  input  wire logic          ready_i
);

  logic          v1_q, v2_q;
  logic          adv1, adv2;
  fps_pkg::fr1_t s1_d, s1_q;
  fps_pkg::fr2_t s2_d, s2_q;

  logic signed [fps_pkg::NRM_W-1:0] nx, ny;
  logic [fps_pkg::SD_W-1:0]         sd;
  logic signed [fps_pkg::DOT_W-1:0] dot, dot_rnd;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    // normal channel 0..1 mapped to -1..1
    nx = $signed({2'b00, pix_i.normal_x}) <<< 1;
    nx = nx - fps_pkg::NRM_W'(fps_pkg::ONE_Q);
    ny = $signed({2'b00, pix_i.normal_y}) <<< 1;
    ny = ny - fps_pkg::NRM_W'(fps_pkg::ONE_Q);
    if (pix_i.density < fps_pkg::IN_W'(fps_pkg::C03)) begin
      sd = fps_pkg::SD_W'(fps_pkg::IN_W'(fps_pkg::C03) - pix_i.density);
    end else begin
      sd = '0;
    end
    s1_d.px  = nx * cfg_i.ldx;
    s1_d.py  = ny * cfg_i.ldy;
    s1_d.pz  = $signed({cfg_i.ldz, {(fps_pkg::FRAC_BITS-1){1'b0}}});
    s1_d.sss = fps_pkg::SSS_W'(sd) * fps_pkg::SSS_W'(cfg_i.scatter);
    s1_d.fi  = fps_pkg::FI_W'(cfg_i.fresnel) * fps_pkg::FI_W'(cfg_i.irid);
    s1_d.rim = fps_pkg::RIM_W'(pix_i.rim_level) * fps_pkg::RIM_W'(fps_pkg::C04);
    s1_d.ao  = pix_i.occlusion;
  end

  always_comb begin
    dot = fps_pkg::DOT_W'(s1_q.px) + fps_pkg::DOT_W'(s1_q.py) + fps_pkg::DOT_W'(s1_q.pz);
    dot_rnd = dot + fps_pkg::DOT_W'(1 << (fps_pkg::FRAC_BITS - 1));
    if (dot > 0) begin
      s2_d.diff = dot_rnd[fps_pkg::FRAC_BITS +: fps_pkg::DIFF_W];
    end else begin
      s2_d.diff = '0;
    end
    s2_d.sss = s1_q.sss;
    s2_d.fi  = s1_q.fi;
    s2_d.rim = s1_q.rim;
    s2_d.ao  = s1_q.ao;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule

`default_nettype wire

[rtl/fps_mix.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_mix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire fps_pkg::fr2_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output fps_pkg::mx2_t      data_o,
  input  wire logic          ready_i
);

  logic          v1_q, v2_q;
  logic          adv1, adv2;
  fps_pkg::mx1_t s1_d, s1_q;
  fps_pkg::mx2_t s2_d, s2_q;

  logic [fps_pkg::DT_W-3:0]  dprod;
  logic [fps_pkg::DT_W-1:0]  diff_t;
  logic [fps_pkg::CMN_W-1:0] common;
  logic [fps_pkg::CH_W-1:0]  base_rg, base_b, fi2;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    dprod   = (fps_pkg::DT_W-2)'(data_i.diff) * (fps_pkg::DT_W-2)'(fps_pkg::C01);
    diff_t  = {dprod, 2'b00};
    common  = fps_pkg::CMN_W'(diff_t) + fps_pkg::CMN_W'({data_i.sss, 2'b00});
    base_rg = fps_pkg::CH_W'(fps_pkg::C005) << fps_pkg::TERM_SH;
    base_b  = fps_pkg::CH_W'(fps_pkg::C008) << fps_pkg::TERM_SH;
    fi2     = fps_pkg::CH_W'({data_i.fi, 1'b0});
    // red tint 0.5*f*i, blue tint 1.5 times that
    s1_d.ch[2] = base_rg + fps_pkg::CH_W'(common) + fi2;
    s1_d.ch[1] = base_rg + fps_pkg::CH_W'(common);
    s1_d.ch[0] = base_b + fps_pkg::CH_W'(common) + fi2 + fps_pkg::CH_W'(data_i.fi);
    s1_d.rim   = data_i.rim;
    s1_d.ao    = data_i.ao;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_d.ch[c] = fps_pkg::OCC_W'(s1_q.ch[c]) * fps_pkg::OCC_W'(s1_q.ao);
    end
    s2_d.rim = s1_q.rim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) s1_q <= s1_d;
    if (adv2 && v1_q) s2_q <= s2_d;
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule

`default_nettype wire

[rtl/fps_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module fps_out (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire fps_pkg::mx2_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic [31:0]        pixel_o,
  input  wire logic          ready_i
);

  localparam logic [fps_pkg::LIM_W-1:0] Lim = fps_pkg::LIM_W'(1) << fps_pkg::ACC_SH;

  logic v1_q, v2_q;
  logic adv1, adv2;

  logic [2:0][fps_pkg::LIM_W-1:0]  u_d, u_q;
  logic [2:0][fps_pkg::SUM_W-1:0]  sum;
  logic [2:0][fps_pkg::BYTE_W-1:0] scl;
  logic [2:0][7:0]                 byte_d;
  logic [31:0]                     pix_d, pix_q;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = fps_pkg::SUM_W'(data_i.ch[c])
             + fps_pkg::SUM_W'({data_i.rim, {fps_pkg::TERM_SH{1'b0}}});
      if (sum[c] > fps_pkg::SUM_W'(Lim)) begin
        u_d[c] = Lim;
      end else begin
        u_d[c] = sum[c][fps_pkg::LIM_W-1:0];
      end
    end
  end

  // x*255 as x*256 - x, then round half up
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scl[c] = fps_pkg::BYTE_W'({u_q[c], 8'h00}) - fps_pkg::BYTE_W'(u_q[c])
             + fps_pkg::BYTE_W'(Lim >> 1);
      byte_d[c] = scl[c][fps_pkg::ACC_SH +: 8];
    end
    pix_d = {8'hFF, byte_d[2], byte_d[1], byte_d[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) u_q <= u_d;
    if (adv2 && v1_q) pix_q <= pix_d;
  end

  assign valid_o = v2_q;
  assign pixel_o = pix_q;

endmodule

`default_nettype wire

[rtl/feather_pixel_shader.sv]
// Feather pixel shader: takes one pixel item (density, normal x/y, occlusion,
// rim level, each unsigned Q.12) and returns one opaque ARGB8 pixel. The block
// is a six-stage pipeline: product stage, diffuse dot/round, channel sums,
// occlusion multiply, rim add and clamp, scale to bytes. It accepts one item
// every clock cycle unless output backpressure has filled the stages; each item
// moves through the stage registers in that order before its result is offered.
// Output backpressure stalls full stages without loss while empty stages keep
// advancing. Light direction and gains are written through the wr_* port; the
// user must write them only while the pipe is empty, which the block itself
// does not enforce. Writes to indexes 6 and 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module feather_pixel_shader (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // density[12:0], normal_x[25:13], normal_y[38:26], occlusion[51:39],
  // rim_level[64:52], zero pad [71:65]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pixel_argb[31:0]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        wr_en_i,
  input  wire logic [2:0]  wr_idx_i,
  input  wire logic [15:0] wr_data_i
);

  localparam int CntW = $clog2(fps_pkg::PIPE_DEPTH + 1);

  fps_pkg::cfg_t cfg_q;
  fps_pkg::pix_t pix;
  fps_pkg::fr2_t fr_data;
  fps_pkg::mx2_t mx_data;
  logic          fr_valid, fr_ready;
  logic          mx_valid, mx_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ldx     <= '0;
      cfg_q.ldy     <= '0;
      cfg_q.ldz     <= 16'sd4096;
      cfg_q.scatter <= 16'd4096;
      cfg_q.fresnel <= 16'd4096;
      cfg_q.irid    <= '0;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        fps_pkg::REG_LIGHT_X:  cfg_q.ldx     <= wr_data_i;
        fps_pkg::REG_LIGHT_Y:  cfg_q.ldy     <= wr_data_i;
        fps_pkg::REG_LIGHT_Z:  cfg_q.ldz     <= wr_data_i;
        fps_pkg::REG_SCATTER:  cfg_q.scatter <= wr_data_i;
        fps_pkg::REG_FRESNEL:  cfg_q.fresnel <= wr_data_i;
        fps_pkg::REG_IRIDESCE: cfg_q.irid    <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign pix.density   = s_axis_tdata[12:0];
  assign pix.normal_x  = s_axis_tdata[25:13];
  assign pix.normal_y  = s_axis_tdata[38:26];
  assign pix.occlusion = s_axis_tdata[51:39];
  assign pix.rim_level = s_axis_tdata[64:52];

  fps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .pix_i   (pix),
    .ready_o (s_axis_tready),
    .valid_o (fr_valid),
    .data_o  (fr_data),
    .ready_i (fr_ready)
  );

  fps_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .data_i  (fr_data),
    .ready_o (fr_ready),
    .valid_o (mx_valid),
    .data_o  (mx_data),
    .ready_i (mx_ready)
  );

  fps_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mx_valid),
    .data_i  (mx_data),
    .ready_o (mx_ready),
    .valid_o (m_axis_tvalid),
    .pixel_o (m_axis_tdata),
    .ready_i (m_axis_tready)
  );

  // items in flight, for checks only
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) inflight_d = inflight_q + CntW'(1);
    if (!in_acc && out_acc) inflight_d = inflight_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(fps_pkg::PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_empty_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> !m_axis_tvalid)
    else $error("result without a pending item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'hFF))
    else $error("pixel is not opaque");

endmodule

`default_nettype wire
